### hdl/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types and constants for the framed byte ring buffer.
// ----------------------------------------------------------------------------
package frb_pkg;

   // request command codes as they arrive on the port
   localparam logic [2:0] CMD_PUSH  = 3'd0;
   localparam logic [2:0] CMD_POP   = 3'd1;
   localparam logic [2:0] CMD_PEEK  = 3'd2;
   localparam logic [2:0] CMD_QUERY = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   // response status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_SHORT = 2'd2;

   localparam int unsigned CNT_W    = 7;   // run count field width
   localparam int unsigned HDR_W    = 5;   // header size register width
   localparam int unsigned LEN_W    = 32;  // frame length word width
   localparam int unsigned OQ_DEPTH = 4;   // response queue depth
   localparam int unsigned OQ_AW    = 2;
   localparam int unsigned OQ_CW    = 3;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_PUSH,
      OP_POP,
      OP_PEEK,
      OP_QUERY,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [7:0]       data;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_QRD,
      S_QDONE
   } state_type;

endpackage

### hdl/frb_ram.sv
// ----------------------------------------------------------------------------
// frb_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module frb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/frb_front.sv
// ----------------------------------------------------------------------------
// frb_front
// Accepts requests, classifies the command and queues it for the back end.
// ----------------------------------------------------------------------------
module frb_front #(
   parameter int unsigned MAX_RUN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_cmd,
   input  logic [7:0]                    req_push_byte,
   input  logic [frb_pkg::CNT_W-1:0]     req_byte_count,
   output logic                          deq_valid,
   input  logic                          deq_ready,
   output frb_pkg::cmd_type              deq_cmd
);

   frb_pkg::cmd_type            class_cmd;
   logic [frb_pkg::CNT_W-1:0]   sat_count;
   frb_pkg::cmd_type            slot_ff [2];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  cnt_ff, cnt_in;
   logic                        enq, deq;

   // saturate run length, zero-length runs are no-ops
   always_comb begin
      sat_count = (req_byte_count > frb_pkg::CNT_W'(MAX_RUN)) ?
                  frb_pkg::CNT_W'(MAX_RUN) : req_byte_count;
      class_cmd.data  = req_push_byte;
      class_cmd.count = sat_count;
      unique case (req_cmd)
         frb_pkg::CMD_PUSH:  class_cmd.op = frb_pkg::OP_PUSH;
         frb_pkg::CMD_POP:   class_cmd.op = (sat_count == '0) ? frb_pkg::OP_NOP :
                                                                 frb_pkg::OP_POP;
         frb_pkg::CMD_PEEK:  class_cmd.op = (sat_count == '0) ? frb_pkg::OP_NOP :
                                                                 frb_pkg::OP_PEEK;
         frb_pkg::CMD_QUERY: class_cmd.op = frb_pkg::OP_QUERY;
         frb_pkg::CMD_CLEAR: class_cmd.op = frb_pkg::OP_CLEAR;
         default:            class_cmd.op = frb_pkg::OP_NOP;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign enq       = req_valid && req_ready;
   assign deq_valid = (cnt_ff != 2'd0);
   assign deq       = deq_valid && deq_ready;
   assign deq_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(enq) - 2'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= class_cmd;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("front queue count out of range");

endmodule

### hdl/frb_out_q.sv
// ----------------------------------------------------------------------------
// frb_out_q
// Response queue between the back end and the response channel.
// ----------------------------------------------------------------------------
module frb_out_q #(
   parameter int unsigned WIDTH = 57
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  logic [WIDTH-1:0]          push_data,
   output logic [frb_pkg::OQ_CW-1:0] fill_cnt,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output logic [WIDTH-1:0]          pop_data
);

   logic [WIDTH-1:0]          slot_ff [frb_pkg::OQ_DEPTH];
   logic [frb_pkg::OQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [frb_pkg::OQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [frb_pkg::OQ_CW-1:0] cnt_ff, cnt_in;
   logic                      pop;

   assign pop_valid = (cnt_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign fill_cnt  = cnt_ff;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + frb_pkg::OQ_CW'(push_valid) - frb_pkg::OQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (cnt_ff != frb_pkg::OQ_CW'(frb_pkg::OQ_DEPTH)))
      else $error("response queue overflow");

endmodule

### hdl/frb_back.sv
// ----------------------------------------------------------------------------
// frb_back
// Executes queued commands against the byte store and emits responses.
// ----------------------------------------------------------------------------
module frb_back #(
   parameter int unsigned CAPACITY = 4096,
   localparam int unsigned AW  = $clog2(CAPACITY),
   localparam int unsigned CW  = $clog2(CAPACITY + 1),
   localparam int unsigned OW  = 8 + 1 + 2 + CW + 1 + frb_pkg::LEN_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [frb_pkg::HDR_W-1:0]  header_size,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  frb_pkg::cmd_type           cmd,
   input  logic [frb_pkg::OQ_CW-1:0]  out_cnt,
   output logic                       push_valid,
   output logic [OW-1:0]              push_data
);

   frb_pkg::state_type          state_ff, state_in;
   logic [AW-1:0]               rp_ff, rp_in;
   logic [AW-1:0]               wp_ff, wp_in;
   logic [CW-1:0]               held_ff, held_in;
   logic [AW-1:0]               run_ptr_ff, run_ptr_in;
   logic [frb_pkg::CNT_W-1:0]   run_rem_ff, run_rem_in;
   logic                        run_pop_ff, run_pop_in;
   logic [1:0]                  qidx_ff, qidx_in;
   logic [23:0]                 len_ff, len_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_ram_ff, s1_ram_in;
   logic                        s1_last_ff, s1_last_in;
   logic [1:0]                  s1_status_ff, s1_status_in;
   logic [CW-1:0]               s1_fill_ff, s1_fill_in;
   logic                        s1_ready_ff, s1_ready_in;
   logic [frb_pkg::LEN_W-1:0]   s1_len_ff, s1_len_in;
   logic                        ram_wr_en, ram_rd_en;
   logic [7:0]                  ram_rd_data;
   logic                        credit, take, short_run, query_ok;
   logic [frb_pkg::LEN_W-1:0]   full_len;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   frb_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (cmd.data),
      .rd_en   (ram_rd_en),
      .rd_addr (run_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // room in the response queue for one more result
   assign credit = (out_cnt + frb_pkg::OQ_CW'(s1_valid_ff)) <
                   frb_pkg::OQ_CW'(frb_pkg::OQ_DEPTH);
   assign take      = (state_ff == frb_pkg::S_IDLE) && cmd_valid && credit;
   assign cmd_ready = take;
   assign short_run = 32'(cmd.count) > 32'(held_ff);
   assign query_ok  = (32'(held_ff) > 32'(header_size)) && (32'(held_ff) >= 32'd4);
   assign full_len  = {ram_rd_data, len_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frb_pkg::S_IDLE: begin
            if (take) begin
               if ((cmd.op == frb_pkg::OP_POP || cmd.op == frb_pkg::OP_PEEK) &&
                   !short_run) begin
                  state_in = frb_pkg::S_RUN;
               end else if (cmd.op == frb_pkg::OP_QUERY && query_ok) begin
                  state_in = frb_pkg::S_QRD;
               end
            end
         end
         frb_pkg::S_RUN: begin
            if (credit && run_rem_ff == frb_pkg::CNT_W'(1)) begin
               state_in = frb_pkg::S_IDLE;
            end
         end
         frb_pkg::S_QRD: begin
            if (qidx_ff == 2'd3) begin
               state_in = frb_pkg::S_QDONE;
            end
         end
         frb_pkg::S_QDONE: begin
            if (credit) begin
               state_in = frb_pkg::S_IDLE;
            end
         end
         default: state_in = frb_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      held_in      = held_ff;
      run_ptr_in   = run_ptr_ff;
      run_rem_in   = run_rem_ff;
      run_pop_in   = run_pop_ff;
      qidx_in      = qidx_ff;
      len_in       = len_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      s1_valid_in  = 1'b0;
      s1_ram_in    = 1'b0;
      s1_last_in   = 1'b1;
      s1_status_in = frb_pkg::STAT_OK;
      s1_fill_in   = held_ff;
      s1_ready_in  = 1'b0;
      s1_len_in    = '0;
      unique case (state_ff)
         frb_pkg::S_IDLE: begin
            if (take) begin
               unique case (cmd.op)
                  frb_pkg::OP_PUSH: begin
                     s1_valid_in = 1'b1;
                     if (held_ff == CW'(CAPACITY)) begin
                        s1_status_in = frb_pkg::STAT_FULL;
                     end else begin
                        ram_wr_en  = 1'b1;
                        wp_in      = wrap_inc(wp_ff);
                        held_in    = held_ff + 1'b1;
                        s1_fill_in = held_ff + 1'b1;
                     end
                  end
                  frb_pkg::OP_POP, frb_pkg::OP_PEEK: begin
                     if (short_run) begin
                        s1_valid_in  = 1'b1;
                        s1_status_in = frb_pkg::STAT_SHORT;
                     end else begin
                        run_ptr_in = rp_ff;
                        run_rem_in = cmd.count;
                        run_pop_in = (cmd.op == frb_pkg::OP_POP);
                        if (cmd.op == frb_pkg::OP_POP) begin
                           held_in = held_ff - CW'(cmd.count);
                        end
                     end
                  end
                  frb_pkg::OP_QUERY: begin
                     if (query_ok) begin
                        run_ptr_in = rp_ff;
                        qidx_in    = 2'd0;
                     end else begin
                        s1_valid_in = 1'b1;
                     end
                  end
                  frb_pkg::OP_CLEAR: begin
                     rp_in       = '0;
                     wp_in       = '0;
                     held_in     = '0;
                     s1_valid_in = 1'b1;
                     s1_fill_in  = '0;
                  end
                  default: begin
                     s1_valid_in = 1'b1;
                  end
               endcase
            end
         end
         frb_pkg::S_RUN: begin
            if (credit) begin
               ram_rd_en   = 1'b1;
               s1_valid_in = 1'b1;
               s1_ram_in   = 1'b1;
               s1_last_in  = (run_rem_ff == frb_pkg::CNT_W'(1));
               run_ptr_in  = wrap_inc(run_ptr_ff);
               run_rem_in  = run_rem_ff - 1'b1;
               if (run_rem_ff == frb_pkg::CNT_W'(1) && run_pop_ff) begin
                  rp_in = wrap_inc(run_ptr_ff);
               end
            end
         end
         frb_pkg::S_QRD: begin
            ram_rd_en  = 1'b1;
            run_ptr_in = wrap_inc(run_ptr_ff);
            qidx_in    = qidx_ff + 1'b1;
            // byte from the previous read lands now
            case (qidx_ff)
               2'd1:    len_in[7:0]   = ram_rd_data;
               2'd2:    len_in[15:8]  = ram_rd_data;
               2'd3:    len_in[23:16] = ram_rd_data;
               default: len_in        = len_ff;
            endcase
         end
         frb_pkg::S_QDONE: begin
            // last header byte stays on the read port until taken
            if (credit) begin
               s1_valid_in = 1'b1;
               s1_len_in   = full_len;
               s1_ready_in = full_len[frb_pkg::LEN_W-1] ||
                             (32'(held_ff) >= full_len);
            end
         end
         default: begin
            s1_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= frb_pkg::S_IDLE;
         rp_ff       <= '0;
         wp_ff       <= '0;
         held_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         held_ff     <= held_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ptr_ff   <= run_ptr_in;
      run_rem_ff   <= run_rem_in;
      run_pop_ff   <= run_pop_in;
      qidx_ff      <= qidx_in;
      len_ff       <= len_in;
      s1_ram_ff    <= s1_ram_in;
      s1_last_ff   <= s1_last_in;
      s1_status_ff <= s1_status_in;
      s1_fill_ff   <= s1_fill_in;
      s1_ready_ff  <= s1_ready_in;
      s1_len_ff    <= s1_len_in;
   end

   assign push_valid = s1_valid_ff;
   assign push_data  = {(s1_ram_ff ? ram_rd_data : 8'd0), s1_last_ff, s1_status_ff,
                        s1_fill_ff, s1_ready_ff, s1_len_ff};

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(CAPACITY))
      else $error("bytes held exceeds capacity");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frb_pkg::S_RUN) |-> (run_rem_ff != '0))
      else $error("run state with nothing left to read");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store written and read in one cycle");

   a_query_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == frb_pkg::S_QRD && qidx_ff == 2'd3) |=> (state_ff == frb_pkg::S_QDONE))
      else $error("frame query did not finish header reads");

endmodule

### hdl/framed_byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// framed_byte_ring_buffer
// Circular byte store with run pop/peek and length-prefixed frame query.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_ready carrying a command (push, pop run,
// peek run, frame query, clear), a byte to push and a run count. Every
// request yields one response on rsp_valid/rsp_ready, except a successful
// pop or peek of n bytes which yields n responses, the last one flagged by
// rsp_last_of_run. csr_wr_en/csr_wr_data write the header size at any time
// the block is idle.
// A front stage classifies requests into a two-entry queue; the back end
// owns the pointers and the byte RAM and feeds a four-entry response queue.
// Push, clear and refused commands stream through the back end at one
// request per cycle while the response queue has room. A run of n bytes
// makes one RAM read per cycle while the response queue has room. A frame
// query makes four header reads on the single RAM read port plus setup and
// compare. A response passes through the front queue, the back end's output
// register and the response queue before it can be taken.
// Reset empties both queues and zeroes the pointers and fill count; the
// store contents are not cleared. When the receiver stalls the response
// queue fills, the back end stops, and req_ready drops once the front
// queue is full.
// ----------------------------------------------------------------------------
module framed_byte_ring_buffer #(
   parameter int unsigned CAPACITY = 4096,
   parameter int unsigned MAX_RUN  = 64,
   localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_cmd,
   input  logic [7:0]                        req_push_byte,
   input  logic [frb_pkg::CNT_W-1:0]         req_byte_count,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_of_run,
   output logic [1:0]                        rsp_status,
   output logic [CW-1:0]                     rsp_fill_level,
   output logic                              rsp_frame_ready,
   output logic signed [frb_pkg::LEN_W-1:0]  rsp_frame_length,
   input  logic                              csr_wr_en,
   input  logic [frb_pkg::HDR_W-1:0]         csr_wr_data
);

   localparam int unsigned OW = 8 + 1 + 2 + CW + 1 + frb_pkg::LEN_W;

   logic [frb_pkg::HDR_W-1:0]  header_size_ff, header_size_in;
   logic                       q_valid, q_ready;
   frb_pkg::cmd_type           q_cmd;
   logic [frb_pkg::OQ_CW-1:0]  out_cnt;
   logic                       res_valid;
   logic [OW-1:0]              res_data;
   logic [OW-1:0]              rsp_data;

   assign header_size_in = csr_wr_en ? csr_wr_data : header_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_size_ff <= frb_pkg::HDR_W'(5);
      end else begin
         header_size_ff <= header_size_in;
      end
   end

   frb_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_push_byte  (req_push_byte),
      .req_byte_count (req_byte_count),
      .deq_valid      (q_valid),
      .deq_ready      (q_ready),
      .deq_cmd        (q_cmd)
   );

   frb_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .header_size (header_size_ff),
      .cmd_valid   (q_valid),
      .cmd_ready   (q_ready),
      .cmd         (q_cmd),
      .out_cnt     (out_cnt),
      .push_valid  (res_valid),
      .push_data   (res_data)
   );

   frb_out_q #(
      .WIDTH (OW)
   ) u_out_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_data  (res_data),
      .fill_cnt   (out_cnt),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_data)
   );

   assign rsp_out_byte     = rsp_data[OW-1 -: 8];
   assign rsp_last_of_run  = rsp_data[OW-9];
   assign rsp_status       = rsp_data[OW-10 -: 2];
   assign rsp_fill_level   = rsp_data[OW-12 -: CW];
   assign rsp_frame_ready  = rsp_data[frb_pkg::LEN_W];
   assign rsp_frame_length = rsp_data[frb_pkg::LEN_W-1:0];

endmodule

### sim/framed_byte_ring_buffer_test.sv
// ----------------------------------------------------------------------------
// framed_byte_ring_buffer_test
// Self-checking bench for the framed byte ring buffer.
// ----------------------------------------------------------------------------
// Sends push, pop run, peek run, frame query, clear and unknown requests in
// bursts against a receiver that stalls on its own pattern. It keeps a mirror
// of the byte store, both pointers, the fill count and the header size, and
// from it predicts every response. Responses are compared field by field, in
// order. Random traffic is mostly length-prefixed frames followed by
// queries and runs. One long receiver hold-off backs the block up to its
// request port.
// ----------------------------------------------------------------------------
module framed_byte_ring_buffer_test;

   localparam int STORE_DEPTH  = 4096;
   localparam int RUN_MAX      = 64;
   localparam int FILL_W       = 13;
   localparam logic [frb_pkg::HDR_W-1:0] HDR_RESET = 5'd5;
   localparam logic [2:0] CMD_TOP_CODE = 3'd7;
   localparam int REPORT_MAX   = 10;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic [7:0]        out_byte;
      logic              last;
      logic [1:0]        status;
      logic [FILL_W-1:0] fill_level;
      logic              frame_ready;
      logic [31:0]       frame_length;
   } rsp_item_type;

   class ring_tracker;
      logic [7:0]                 mirror [STORE_DEPTH];
      logic [11:0]                rd_ptr   = '0;
      logic [11:0]                wr_ptr   = '0;
      logic [FILL_W-1:0]          held     = '0;
      logic [frb_pkg::HDR_W-1:0]  hdr_size = HDR_RESET;
      rsp_item_type               due [$];
      int requests   = 0;
      int checked    = 0;
      int mismatches = 0;
      int full_seen  = 0;
      int short_seen = 0;
      int ready_seen = 0;

      // works out the responses of one accepted request
      function void note_request(logic [2:0] cmd, logic [7:0] data,
                                 logic [frb_pkg::CNT_W-1:0] count);
         rsp_item_type r;
         int unsigned  run;
         int unsigned  i;
         logic [11:0]  p;
         logic [31:0]  word;
         bit           multi;
         r      = '0;
         r.last = 1'b1;
         multi  = 1'b0;
         requests++;
         case (cmd) inside
            frb_pkg::CMD_PUSH: begin
               if (held == FILL_W'(STORE_DEPTH)) begin
                  r.status = frb_pkg::STAT_FULL;
               end else begin
                  mirror[wr_ptr] = data;
                  wr_ptr++;
                  held++;
               end
            end
            frb_pkg::CMD_POP, frb_pkg::CMD_PEEK: begin
               run = (count > RUN_MAX) ? RUN_MAX : count;
               if (run > held) begin
                  r.status = frb_pkg::STAT_SHORT;
               end else if (run != 0) begin
                  multi = 1'b1;
                  p     = rd_ptr;
                  if (cmd == frb_pkg::CMD_POP) held -= FILL_W'(run);
                  for (i = 0; i < run; i++) begin
                     r.out_byte   = mirror[p];
                     r.last       = (i == run - 1);
                     r.fill_level = held;
                     due.push_back(r);
                     p++;
                  end
                  if (cmd == frb_pkg::CMD_POP) rd_ptr = p;
               end
            end
            frb_pkg::CMD_QUERY: begin
               if (held > hdr_size && held >= 4) begin
                  // little-endian length word, pointer wraps with the store
                  p = rd_ptr;
                  for (i = 0; i < 4; i++) begin
                     word[8*i +: 8] = mirror[p];
                     p++;
                  end
                  r.frame_length = word;
                  r.frame_ready  = word[31] || (32'(held) >= word);
               end
            end
            frb_pkg::CMD_CLEAR: begin
               rd_ptr = '0;
               wr_ptr = '0;
               held   = '0;
            end
            default: begin
            end
         endcase
         if (!multi) begin
            r.fill_level = held;
            due.push_back(r);
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         checked++;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected response %0d: byte %02h last %0b status %0d fill %0d",
                        checked, got.out_byte, got.last, got.status, got.fill_level);
         end else begin
            want = due.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last ||
                got.status !== want.status || got.fill_level !== want.fill_level ||
                got.frame_ready !== want.frame_ready ||
                got.frame_length !== want.frame_length) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"response %0d mismatch (expected/actual): byte %02h/%02h ",
                            "last %0b/%0b status %0d/%0d fill %0d/%0d ready %0b/%0b ",
                            "length %0d/%0d"},
                           checked, want.out_byte, got.out_byte, want.last, got.last,
                           want.status, got.status, want.fill_level, got.fill_level,
                           want.frame_ready, got.frame_ready,
                           $signed(want.frame_length), $signed(got.frame_length));
            end
            if (want.status == frb_pkg::STAT_FULL) full_seen++;
            if (want.status == frb_pkg::STAT_SHORT) short_seen++;
            if (want.frame_ready) ready_seen++;
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic [2:0]                       req_cmd;
   logic [7:0]                       req_push_byte;
   logic [frb_pkg::CNT_W-1:0]        req_byte_count;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_last_of_run;
   logic [1:0]                       rsp_status;
   logic [FILL_W-1:0]                rsp_fill_level;
   logic                             rsp_frame_ready;
   logic signed [frb_pkg::LEN_W-1:0] rsp_frame_length;
   logic                             csr_wr_en;
   logic [frb_pkg::HDR_W-1:0]        csr_wr_data;

   ring_tracker tracker;
   int          burst_left;
   bit          rx_stalls;
   bit          hold_off_req;
   int          cycle_count;

   framed_byte_ring_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_push_byte    (req_push_byte),
      .req_byte_count   (req_byte_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_status       (rsp_status),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_frame_length (rsp_frame_length),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic issue(input logic [2:0] cmd, input logic [7:0] data,
                        input logic [frb_pkg::CNT_W-1:0] count);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_push_byte  <= data;
      req_byte_count <= count;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(cmd, data, count);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (tracker.due.size() != 0) @(negedge clock);
   endtask

   task automatic write_header(input logic [frb_pkg::HDR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.hdr_size = value;
   endtask

   task automatic random_traffic(input int n_items);
      int          sent;
      int          kind;
      int          k;
      int          lim;
      int          pick;
      logic [31:0] word;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            // length word, payload, then ask whether the frame is complete
            pick = $urandom_range(0, 7);
            if (pick == 0) word = $urandom | 32'h8000_0000;
            else if (pick == 1) word = $urandom_range(65, 100000);
            else word = $urandom_range(0, 24);
            for (k = 0; k < 4; k++)
               issue(frb_pkg::CMD_PUSH, word[8*k +: 8], frb_pkg::CNT_W'($urandom));
            lim = $urandom_range(0, 24);
            for (k = 0; k < lim; k++)
               issue(frb_pkg::CMD_PUSH, 8'($urandom), frb_pkg::CNT_W'($urandom));
            issue(frb_pkg::CMD_QUERY, 8'($urandom), frb_pkg::CNT_W'($urandom));
            sent += lim + 5;
         end else if (kind < 75) begin
            lim = (tracker.held > RUN_MAX) ? RUN_MAX : int'(tracker.held);
            k   = (lim == 0) ? 0 : $urandom_range(1, lim);
            issue(frb_pkg::CMD_QUERY, 8'($urandom), frb_pkg::CNT_W'($urandom));
            issue($urandom_range(0, 1) ? frb_pkg::CMD_POP : frb_pkg::CMD_PEEK,
                  8'($urandom), frb_pkg::CNT_W'(k));
            sent += 2;
         end else if (kind < 87) begin
            // any count: zero, too many, above the run limit
            issue($urandom_range(0, 1) ? frb_pkg::CMD_POP : frb_pkg::CMD_PEEK,
                  8'($urandom), frb_pkg::CNT_W'($urandom));
            sent++;
         end else if (kind < 93) begin
            issue(frb_pkg::CMD_PUSH, 8'($urandom), frb_pkg::CNT_W'($urandom));
            sent++;
         end else if (kind < 97) begin
            issue(frb_pkg::CMD_CLEAR, 8'($urandom), frb_pkg::CNT_W'($urandom));
            sent++;
         end else begin
            issue(3'($urandom_range(int'(frb_pkg::CMD_CLEAR) + 1, int'(CMD_TOP_CODE))),
                  8'($urandom), frb_pkg::CNT_W'($urandom));
            sent++;
         end
      end
   endtask

   initial begin : receiver
      int run_left;
      int stall_left;
      int hold_left;
      run_left   = 0;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            tracker.check_response({rsp_out_byte, rsp_last_of_run, rsp_status,
                                    rsp_fill_level, rsp_frame_ready, rsp_frame_length});
         @(negedge clock);
         if (hold_off_req && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!rx_stalls) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (run_left > 0) begin
               run_left--;
            end else begin
               run_left   = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 50)
                                                        : $urandom_range(0, 9);
               stall_left = $urandom_range(1, 5);
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int i;
      tracker        = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = frb_pkg::CMD_PUSH;
      req_push_byte  = '0;
      req_byte_count = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = HDR_RESET;
      burst_left     = 0;
      rx_stalls      = 1'b1;
      hold_off_req   = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, unknown codes, header boundary, negative length
      issue(frb_pkg::CMD_QUERY, 8'h00, 7'd0);
      issue(frb_pkg::CMD_POP, 8'hFF, 7'd1);
      issue(frb_pkg::CMD_PEEK, 8'h00, 7'd0);
      for (i = int'(frb_pkg::CMD_CLEAR) + 1; i <= int'(CMD_TOP_CODE); i++)
         issue(3'(i), 8'($urandom), frb_pkg::CNT_W'($urandom));
      issue(frb_pkg::CMD_PUSH, 8'h06, 7'h7F);
      issue(frb_pkg::CMD_PUSH, 8'h00, 7'h00);
      issue(frb_pkg::CMD_PUSH, 8'h00, 7'h55);
      issue(frb_pkg::CMD_PUSH, 8'h00, 7'h2A);
      issue(frb_pkg::CMD_PUSH, 8'hFF, 7'd0);
      issue(frb_pkg::CMD_QUERY, 8'h00, 7'd0);   // held equals header size
      issue(frb_pkg::CMD_PUSH, 8'h00, 7'd0);
      issue(frb_pkg::CMD_QUERY, 8'h00, 7'd0);
      issue(frb_pkg::CMD_PEEK, 8'h00, 7'h7F);   // saturates, still more than held
      issue(frb_pkg::CMD_PEEK, 8'h00, 7'd6);
      issue(frb_pkg::CMD_POP, 8'h00, 7'd6);
      issue(frb_pkg::CMD_PUSH, 8'h00, 7'd0);
      issue(frb_pkg::CMD_PUSH, 8'h00, 7'd0);
      issue(frb_pkg::CMD_PUSH, 8'h00, 7'd0);
      issue(frb_pkg::CMD_PUSH, 8'h80, 7'd0);
      issue(frb_pkg::CMD_PUSH, 8'h7F, 7'd0);
      issue(frb_pkg::CMD_PUSH, 8'h01, 7'd0);
      issue(frb_pkg::CMD_QUERY, 8'h00, 7'd0);
      issue(frb_pkg::CMD_POP, 8'h00, 7'd0);
      issue(frb_pkg::CMD_CLEAR, 8'h00, 7'd0);
      issue(frb_pkg::CMD_QUERY, 8'h00, 7'd0);
      wait_drained();

      write_header(5'd4);
      random_traffic(130);
      wait_drained();

      write_header(5'($urandom_range(5, 15)));
      hold_off_req = 1'b1;
      random_traffic(130);
      wait_drained();

      write_header(5'd16);
      random_traffic(130);
      wait_drained();

      rx_stalls = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests over every command code and a long hold-off, %0d checked",
               tracker.requests, tracker.checked);
      $display("full drops %0d, short runs %0d, frames ready %0d, mismatches %0d",
               tracker.full_seen, tracker.short_seen, tracker.ready_seen,
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
